FILE: rtl/core/ewts_pkg.sv
// Shared types, constants and the microcode program of the earliest-wake scheduler.
// Used by ewts_ctrl, ewts_dpath and earliest_wake_task_scheduler; depends on nothing.
`default_nettype none
package ewts_pkg;

	// table geometry
	localparam int MAX_TASKS = 16;
	localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int COUNT_W   = $clog2(MAX_TASKS + 1);
	localparam int TIME_W    = 32;
	localparam int PC_W      = 4;

	// result field widths
	localparam int OUT_SLOT_W  = 4;
	localparam int OUT_COUNT_W = 5;
	localparam int STATUS_W    = 2;

	// item kinds
	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_EXEC = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// datapath operations
	typedef enum logic [2:0] {
		OP_NOP,
		OP_ADD,
		OP_FULL,
		OP_SCAN,
		OP_EXE1,
		OP_EXE2,
		OP_EMPTY,
		OP_DONE
	} op_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NOSTART,
		C_EXEC,
		C_FULL,
		C_EMPTY,
		C_SCAN_MORE,
		C_OUTBUSY
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctl_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic exec;
		logic full;
		logic empty;
		logic scan_more;
	} dp_flags_t;

	typedef struct packed {
		logic      nostart;
		logic      outbusy;
		dp_flags_t dp;
	} flags_t;

	typedef struct packed {
		logic [OUT_SLOT_W-1:0]  next_slot;
		logic [TIME_W-1:0]      delay_to_next;
		logic [OUT_SLOT_W-1:0]  ran_slot;
		logic [OUT_COUNT_W-1:0] task_count;
		logic [STATUS_W-1:0]    status;
	} res_t;

	// program addresses
	localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
	localparam logic [PC_W-1:0] PC_DISPATCH = 4'd1;
	localparam logic [PC_W-1:0] PC_ADD_CHK  = 4'd2;
	localparam logic [PC_W-1:0] PC_ADD      = 4'd3;
	localparam logic [PC_W-1:0] PC_ADD_FULL = 4'd4;
	localparam logic [PC_W-1:0] PC_SCAN     = 4'd5;
	localparam logic [PC_W-1:0] PC_DRAIN    = 4'd6;
	localparam logic [PC_W-1:0] PC_WAIT_OUT = 4'd7;
	localparam logic [PC_W-1:0] PC_DONE     = 4'd8;
	localparam logic [PC_W-1:0] PC_EXE_CHK  = 4'd9;
	localparam logic [PC_W-1:0] PC_EXE_SCAN = 4'd10;
	localparam logic [PC_W-1:0] PC_EXE_DRN  = 4'd11;
	localparam logic [PC_W-1:0] PC_EXE1     = 4'd12;
	localparam logic [PC_W-1:0] PC_EXE2     = 4'd13;
	localparam logic [PC_W-1:0] PC_EMPTY    = 4'd14;
	localparam logic [PC_W-1:0] PC_SPARE    = 4'd15;

	// microcode ROM: a taken condition jumps to target, otherwise advance by one
	function automatic ctl_t ucode_rom(input logic [PC_W-1:0] pc);
		ctl_t w;
		unique case (pc)
			PC_IDLE:     w = '{OP_NOP,   C_NOSTART,   PC_IDLE};
			PC_DISPATCH: w = '{OP_NOP,   C_EXEC,      PC_EXE_CHK};
			PC_ADD_CHK:  w = '{OP_NOP,   C_FULL,      PC_ADD_FULL};
			PC_ADD:      w = '{OP_ADD,   C_ALWAYS,    PC_SCAN};
			PC_ADD_FULL: w = '{OP_FULL,  C_NEVER,     PC_IDLE};
			PC_SCAN:     w = '{OP_SCAN,  C_SCAN_MORE, PC_SCAN};
			PC_DRAIN:    w = '{OP_NOP,   C_NEVER,     PC_IDLE};
			PC_WAIT_OUT: w = '{OP_NOP,   C_OUTBUSY,   PC_WAIT_OUT};
			PC_DONE:     w = '{OP_DONE,  C_ALWAYS,    PC_IDLE};
			PC_EXE_CHK:  w = '{OP_NOP,   C_EMPTY,     PC_EMPTY};
			PC_EXE_SCAN: w = '{OP_SCAN,  C_SCAN_MORE, PC_EXE_SCAN};
			PC_EXE_DRN:  w = '{OP_NOP,   C_NEVER,     PC_IDLE};
			PC_EXE1:     w = '{OP_EXE1,  C_NEVER,     PC_IDLE};
			PC_EXE2:     w = '{OP_EXE2,  C_ALWAYS,    PC_SCAN};
			PC_EMPTY:    w = '{OP_EMPTY, C_ALWAYS,    PC_WAIT_OUT};
			PC_SPARE:    w = '{OP_NOP,   C_ALWAYS,    PC_IDLE};
			default:     w = '{OP_NOP,   C_ALWAYS,    PC_IDLE};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ewts_ctrl.sv
// Microcode sequencer: step counter, control word fetch and conditional jumps.
// Depends on ewts_pkg for the control word, flags and the program ROM.
`default_nettype none
module ewts_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  ewts_pkg::flags_t flags,
	output ewts_pkg::ctl_t   ctl,
	output logic             idle
);

	logic [ewts_pkg::PC_W-1:0] pc_q;
	logic                      taken;

	// fetch the current control word
	assign ctl  = ewts_pkg::ucode_rom(pc_q);
	assign idle = (pc_q == ewts_pkg::PC_IDLE);

	// evaluate the jump condition
	always_comb begin
		unique case (ctl.cond)
			ewts_pkg::C_NEVER:     taken = 1'b0;
			ewts_pkg::C_ALWAYS:    taken = 1'b1;
			ewts_pkg::C_NOSTART:   taken = flags.nostart;
			ewts_pkg::C_EXEC:      taken = flags.dp.exec;
			ewts_pkg::C_FULL:      taken = flags.dp.full;
			ewts_pkg::C_EMPTY:     taken = flags.dp.empty;
			ewts_pkg::C_SCAN_MORE: taken = flags.dp.scan_more;
			ewts_pkg::C_OUTBUSY:   taken = flags.outbusy;
			default:               taken = 1'b0;
		endcase
	end

	// advance or jump
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ewts_pkg::PC_IDLE;
		end else if (taken) begin
			pc_q <= ctl.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/ewts_dpath.sv
// Datapath: wake-time memory, current time, slot count and the earliest-slot scan.
// Driven by the op field of the microcode word; depends on ewts_pkg.
`default_nettype none
module ewts_dpath (
	input  wire                               clk,
	input  wire                               arst_n,
	input  ewts_pkg::op_t                     op,
	input  wire                               start,
	input  wire                               action_in,
	input  wire  [ewts_pkg::TIME_W-1:0]       delay_in,
	output ewts_pkg::dp_flags_t               flags,
	output ewts_pkg::res_t                    res
);

	localparam int SW = ewts_pkg::SLOT_W;
	localparam int CW = ewts_pkg::COUNT_W;
	localparam int TW = ewts_pkg::TIME_W;

	logic [TW-1:0] wake_mem [ewts_pkg::MAX_TASKS];

	logic [CW-1:0]                count_q;
	logic [TW-1:0]                cur_q;
	logic                         cmp_valid_q;
	logic [SW-1:0]                scan_idx_q;
	logic [SW-1:0]                cmp_idx_q;
	logic [TW-1:0]                rdata_q;
	logic [SW-1:0]                best_q;
	logic [TW-1:0]                best_off_q;
	logic [SW-1:0]                ran_q;
	logic [ewts_pkg::STATUS_W-1:0] status_q;
	logic                         action_q;
	logic [TW-1:0]                delay_q;

	logic [TW-1:0] off;
	logic          take;
	logic          wr_en;
	logic [SW-1:0] wr_addr;
	logic [TW-1:0] wr_data;

	// offset of the entry just read, relative to the current time
	assign off  = rdata_q - cur_q;
	assign take = cmp_valid_q && ((cmp_idx_q == '0) || (off < best_off_q));

	assign flags.exec      = (action_q == ewts_pkg::ACT_EXEC);
	assign flags.full      = (count_q == CW'(ewts_pkg::MAX_TASKS));
	assign flags.empty     = (count_q == '0);
	assign flags.scan_more = (CW'(scan_idx_q) != (count_q - CW'(1)));

	// memory write port: new slot on add, rescheduled slot on execute
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = best_q;
		wr_data = cur_q + delay_q;
		if (op == ewts_pkg::OP_ADD) begin
			wr_en   = 1'b1;
			wr_addr = count_q[SW-1:0];
			wr_data = cur_q;
		end else if (op == ewts_pkg::OP_EXE2) begin
			wr_en = 1'b1;
		end
	end

	// wake-time memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			wake_mem[wr_addr] <= wr_data;
		end
		rdata_q <= wake_mem[scan_idx_q];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cur_q       <= '0;
			cmp_valid_q <= 1'b0;
			scan_idx_q  <= '0;
		end else begin
			cmp_valid_q <= (op == ewts_pkg::OP_SCAN);
			if (op == ewts_pkg::OP_SCAN) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end else begin
				scan_idx_q <= '0;
			end
			if (op == ewts_pkg::OP_ADD) begin
				count_q <= count_q + 1'b1;
			end
			// move time to the earliest wake time
			if (op == ewts_pkg::OP_EXE1) begin
				cur_q <= cur_q + best_off_q;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cmp_idx_q <= scan_idx_q;
		if (start) begin
			action_q <= action_in;
			delay_q  <= delay_in;
		end
		// keep the earliest entry; a tie keeps the lower slot
		if (take) begin
			best_q     <= cmp_idx_q;
			best_off_q <= off;
		end
		unique case (op)
			ewts_pkg::OP_ADD: begin
				ran_q    <= count_q[SW-1:0];
				status_q <= ewts_pkg::ST_OK;
			end
			ewts_pkg::OP_FULL: begin
				ran_q    <= '0;
				status_q <= ewts_pkg::ST_FULL;
			end
			ewts_pkg::OP_EXE2: begin
				ran_q    <= best_q;
				status_q <= ewts_pkg::ST_OK;
			end
			ewts_pkg::OP_EMPTY: begin
				ran_q      <= '0;
				best_q     <= '0;
				best_off_q <= '0;
				status_q   <= ewts_pkg::ST_EMPTY;
			end
			default: begin
			end
		endcase
	end

	assign res.next_slot     = ewts_pkg::OUT_SLOT_W'(best_q);
	assign res.delay_to_next = best_off_q;
	assign res.ran_slot      = ewts_pkg::OUT_SLOT_W'(ran_q);
	assign res.task_count    = ewts_pkg::OUT_COUNT_W'(count_q);
	assign res.status        = status_q;

endmodule
`default_nettype wire

FILE: rtl/core/earliest_wake_task_scheduler.sv
// Earliest-wake task scheduler, one item at a time under a microcoded sequencer.
// The next item is taken in the cycle after the result is loaded; a result not yet taken
// holds the sequencer in its wait step.
// Asynchronous active-low reset clears time, task count, sequencer and output valid.
`default_nettype none
module earliest_wake_task_scheduler (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire [31:0] s_axis_tdata,  // [31:0] delay_us
	input  wire        s_axis_tuser,  // [0] action
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	// [3:0] next_slot, [35:4] delay_to_next, [39:36] ran_slot, [44:40] task_count,
	// [47:45] zero
	output logic [47:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser  // [1:0] status
);

	ewts_pkg::ctl_t      ctl;
	ewts_pkg::flags_t    flags;
	ewts_pkg::dp_flags_t dp_flags;
	ewts_pkg::res_t      res;
	logic                idle;
	logic                start;
	ewts_pkg::res_t      out_q;
	logic                out_valid_q;

	assign s_axis_tready = idle;
	assign start         = s_axis_tvalid && s_axis_tready;

	assign flags.nostart = !s_axis_tvalid;
	assign flags.outbusy = out_valid_q && !m_axis_tready;
	assign flags.dp      = dp_flags;

	ewts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl),
		.idle   (idle)
	);

	ewts_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (ctl.op),
		.start     (start),
		.action_in (s_axis_tuser),
		.delay_in  (s_axis_tdata),
		.flags     (dp_flags),
		.res       (res)
	);

	// hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.op == ewts_pkg::OP_DONE) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == ewts_pkg::OP_DONE) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_q.task_count, out_q.ran_slot,
		out_q.delay_to_next, out_q.next_slot};
	assign m_axis_tuser  = out_q.status;

`ifndef ASSERT_OFF
	// no second item enters while one is at work
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("item accepted while sequencer busy");

	// the result register is only loaded once the previous item is gone
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == ewts_pkg::OP_DONE) |-> (!out_valid_q || m_axis_tready))
		else $error("result overwritten before it was taken");

	// a full-table add reports no slot
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == ewts_pkg::ST_FULL)) |->
		(m_axis_tdata[39:36] == '0))
		else $error("full status with nonzero ran_slot");

	// an empty execute reports zeros and an empty table
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == ewts_pkg::ST_EMPTY)) |->
		((m_axis_tdata[44:40] == '0) && (m_axis_tdata[35:4] == '0)))
		else $error("empty status with stale fields");
`endif

endmodule
`default_nettype wire
